/* sv/wfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit allocator package
// Item and result layouts, operation codes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package wfa_pkg;

  // Field widths of the item and result
  localparam int IDX_W   = 5;
  localparam int FSIZE_W = 16;
  localparam int CNT_W   = 6;

  // Operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [IDX_W-1:0]   block_index;
    logic [FSIZE_W-1:0] block_size;
    logic [FSIZE_W-1:0] file_size;
  } wfa_in_t;

  typedef struct packed {
    logic               granted;
    logic [IDX_W-1:0]   chosen_block;
    logic [FSIZE_W-1:0] chosen_size;
    logic [FSIZE_W-1:0] fragment;
  } wfa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;     // clear one allocation mark during the reset sweep
    logic load_wr;    // write a block size from the accepted item
    logic req_start;  // latch the request and rewind the scan
    logic scan_rd;    // read one table entry
    logic finish;     // mark the winner and present the result
  } wfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic limit_zero;
  } wfa_sts_t;

endpackage

/* sv/wfa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit allocator controller
// Sequences the mark clearing sweep, loads, and the request scan.
// ----------------------------------------------------------------------------
module wfa_ctrl
  import wfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     operation,
  input  wfa_sts_t sts,
  output wfa_cmd_t cmd,
  output logic     busy
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_MARK  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  // Decode state into commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_REQUEST) begin
            cmd.req_start = 1'b1;
            state_nxt     = sts.limit_zero ? ST_DRAIN : ST_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_MARK;
      end
      ST_MARK: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/wfa_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit allocator datapath
// Size table and allocation marks, scan counter, best-fragment tracking
// and the result register.
// ----------------------------------------------------------------------------
module wfa_dpath
  import wfa_pkg::*;
#(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wfa_cmd_t         cmd,
  input  wfa_in_t          in_item,
  input  logic             cfg_wr,
  input  logic [CNT_W-1:0] cfg_data,
  output wfa_sts_t         sts,
  output logic             out_valid,
  output wfa_out_t         out_item
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  // Memories
  logic [SIZE_WIDTH-1:0] size_mem [NUM_BLOCKS];
  logic                  mark_mem [NUM_BLOCKS];

  logic [CNT_W-1:0]      block_count_r;
  logic [AW-1:0]         scan_idx_r;
  logic [CW-1:0]         limit_r;
  logic [CW-1:0]         limit_now;
  logic [SIZE_WIDTH-1:0] fsize_r;

  logic                  rd_vld_r;
  logic [AW-1:0]         rd_idx_r;
  logic [SIZE_WIDTH-1:0] size_q_r;
  logic                  mark_q_r;

  logic                  found_r;
  logic [AW-1:0]         best_idx_r;
  logic [SIZE_WIDTH-1:0] best_size_r;
  logic [SIZE_WIDTH-1:0] best_frag_r;

  logic                  out_valid_r;
  wfa_out_t              out_item_r;

  logic                  cand_fits;
  logic [SIZE_WIDTH-1:0] cand_frag;
  logic                  cand_take;
  logic                  load_in_range;
  logic [AW-1:0]         load_addr;

  // Hold the block count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= CNT_W'(1);
    end else if (cfg_wr) begin
      block_count_r <= cfg_data;
    end
  end

  // Saturate the block count to the table depth
  always_comb begin
    if (32'(block_count_r) > NUM_BLOCKS) begin
      limit_now = CW'(NUM_BLOCKS);
    end else begin
      limit_now = CW'(block_count_r);
    end
  end

  assign sts.limit_zero = (block_count_r == '0);
  assign sts.scan_last  = ((CW'(scan_idx_r) + CW'(1)) == limit_r);
  assign sts.clr_last   = (32'(scan_idx_r) == NUM_BLOCKS - 1);

  // Scan counter, shared by the clearing sweep and the request scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.req_start) begin
      scan_idx_r <= '0;
    end else if (cmd.clr_wr || cmd.scan_rd) begin
      scan_idx_r <= scan_idx_r + AW'(1);
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.req_start) begin
      fsize_r <= SIZE_WIDTH'(in_item.file_size);
      limit_r <= limit_now;
    end
  end

  // Write the size table on a load inside the table
  assign load_in_range = (32'(in_item.block_index) < NUM_BLOCKS);
  assign load_addr     = AW'(in_item.block_index);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_in_range) begin
      size_mem[load_addr] <= SIZE_WIDTH'(in_item.block_size);
    end
  end

  // Read both stores at the scan address
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      size_q_r <= size_mem[scan_idx_r];
      mark_q_r <= mark_mem[scan_idx_r];
    end
    rd_idx_r <= scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
    end
  end

  // Clear marks during the sweep, set the winner's mark at the end
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mark_mem[scan_idx_r] <= 1'b0;
    end else if (cmd.finish && found_r) begin
      mark_mem[best_idx_r] <= 1'b1;
    end
  end

  // Compare the entry just read against the best so far
  assign cand_fits = !mark_q_r && (size_q_r >= fsize_r);
  assign cand_frag = size_q_r - fsize_r;
  assign cand_take = rd_vld_r && cand_fits && (!found_r || (cand_frag > best_frag_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.req_start) begin
      found_r <= 1'b0;
    end else if (cand_take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_take) begin
      best_idx_r  <= rd_idx_r;
      best_size_r <= size_q_r;
      best_frag_r <= cand_frag;
    end
  end

  // Present the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (found_r) begin
        out_item_r.granted      <= 1'b1;
        out_item_r.chosen_block <= IDX_W'(best_idx_r);
        out_item_r.chosen_size  <= FSIZE_W'(best_size_r);
        out_item_r.fragment     <= FSIZE_W'(best_frag_r);
      end else begin
        out_item_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/worst_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit block allocator
// Fixed-partition allocator: loads block sizes, grants requests to the free
// block that leaves the largest fragment.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive in_item and raise start; the item is taken at a clock edge
//   where start is high and busy is low. A load item (operation OP_LOAD)
//   writes one block size, giving no result. A request item (OP_REQUEST)
//   keeps busy high while it scans N entries, N being block_count
//   saturated to NUM_BLOCKS: one table entry read per cycle through the
//   single read port of the size and mark stores, then a drain state to
//   settle the last compare and a mark state to mark the winner. The result
//   follows in the next cycle, and a new item may be taken in that same cycle.
//   Output: out_valid is high for exactly one cycle with out_item; the
//   receiver cannot stall, so it must take the result then.
//   Configuration: cfg_data is written to block_count when cfg_valid is
//   high; cfg_ready is always high. Write only while the block is idle.
//   Reset: rst_n low at a clock edge sets block_count to 1, then busy
//   stays high while the allocation marks are cleared one entry a cycle.
//   Block sizes are undefined until loaded.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator
  import wfa_pkg::*;
#(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  wfa_in_t          in_item,
  output logic             out_valid,
  output wfa_out_t         out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  wfa_cmd_t cmd;
  wfa_sts_t sts;

  assign cfg_ready = 1'b1;

  wfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_item.operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  wfa_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // A result only follows a cycle in which a request was in progress
  a_result_after_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)
  ) else $error("result without a request in progress");

  // Results are never back to back: each needs a new request, with its drain and mark states, in between
  a_result_spaced: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid
  ) else $error("two results in consecutive cycles");

  // A refusal carries all-zero fields
  a_refusal_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.granted) |->
      (out_item.chosen_block == '0) && (out_item.chosen_size == '0) &&
      (out_item.fragment == '0)
  ) else $error("refused request with non-zero fields");

endmodule
